// ===== hdl/ecrl_pkg.sv =====
`default_nettype none

package ecrl_pkg;

    // Configuration port geometry: seven 32-bit registers at 4-byte spacing
    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_DROP_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_WINDOW_LENGTH      = 3'd1;
    localparam logic [2:0] REG_EXEMPT_SEVERITY    = 3'd2;
    localparam logic [2:0] REG_SUMMARY_EVENT_CODE = 3'd3;
    localparam logic [2:0] REG_SUMMARY_SOURCE     = 3'd4;
    localparam logic [2:0] REG_SUMMARY_SEVERITY   = 3'd5;
    localparam logic [2:0] REG_MAX_PAYLOAD_LENGTH = 3'd6;

    localparam logic [15:0] RST_DROP_THRESHOLD     = 16'd16;
    localparam logic [20:0] RST_WINDOW_LENGTH      = 21'd1024;
    localparam logic [15:0] RST_EXEMPT_SEVERITY    = 16'd3;
    localparam logic [15:0] RST_SUMMARY_EVENT_CODE = 16'd0;
    localparam logic [31:0] RST_SUMMARY_SOURCE     = 32'd0;
    localparam logic [15:0] RST_SUMMARY_SEVERITY   = 16'd0;
    localparam logic [7:0]  RST_MAX_PAYLOAD_LENGTH = 8'd220;

    // Summary records always carry an 8-byte payload
    localparam logic [7:0] SUMMARY_PAYLOAD_LEN = 8'd8;

    // Per-class memory word: {dropped, count}
    localparam int CNT_W   = 16;
    localparam int DROP_W  = 32;
    localparam int ENTRY_W = CNT_W + DROP_W;

    typedef enum logic [1:0] {
        ST_LOGGED,
        ST_DROPPED,
        ST_INVALID,
        ST_EXHAUSTED
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DECIDE
    } state_t;

    // Input transaction, laid out to match s_tdata (cpu_id in the low bits)
    typedef struct packed {
        logic [7:0]  pay_len;
        logic [15:0] ev_code;
        logic [15:0] severity;
        logic [31:0] src_comp;
        logic [31:0] cpu_id;
    } event_t;

    typedef struct packed {
        logic        is_summary;
        logic [63:0] record_seq;
        logic [31:0] cpu_id;
        logic [31:0] source;
        logic [15:0] severity;
        logic [15:0] ev_code;
        logic [3:0]  summary_class;
        logic [31:0] summary_dropped;
        status_t     status;
        logic        last;
    } result_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] seq;
        logic [63:0] count;
    } append_t;

    // Record append: length check, then sequence exhaustion, then increment
    function automatic append_t do_append(input logic [63:0] count,
                                          input logic [7:0]  len,
                                          input logic [7:0]  max_len);
        append_t a;
        a.status = ST_LOGGED;
        a.seq    = '0;
        a.count  = count;
        if (len > max_len) begin
            a.status = ST_INVALID;
        end else if (&count) begin
            a.status = ST_EXHAUSTED;
        end else begin
            a.count = count + 64'd1;
            a.seq   = count + 64'd1;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ecrl_ram.sv =====
`default_nettype none

module ecrl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds until next read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/event_class_rate_limiter_top.sv =====
// Event-class rate limiter. Each input transaction is one log event; the block
// returns the summary records it causes followed by the event's own result,
// which alone carries tlast. The per-class accepted and dropped counters live
// in one memory (one word per class). An event inside the current window steps
// through accept, class counter read, then decide and emit. An event that
// finds the window expired sweeps the whole class memory, one class per cycle
// unless a summary stalls, to snapshot and clear the counters. Both paths also
// wait through every cycle in which a summary or the event's result finds the
// output register still held because m_tready is low. The single read port of
// the class memory is why the sweep takes one class at a time. One event is in
// flight at a time; s_tready is high only between events. Counters come out of
// reset cleared at once through per-class valid bits; no clearing pass runs.
`default_nettype none

module event_class_rate_limiter_top
    import ecrl_pkg::*;
#(
    parameter int NUM_CLASSES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB-style configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Event input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // cpu_id[31:0], src_comp[63:32], severity[79:64],
    // ev_code[95:80], pay_len[103:96]
    input  wire logic [103:0]          s_tdata,
    // Result output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // record_seq[63:0], out_cpu_id[95:64], out_source[127:96],
    // out_severity[143:128], out_code[159:144], summary_class[163:160],
    // summary_dropped[195:164], status[197:196], zero fill[199:198]
    output logic      [199:0]          m_tdata,
    // is_summary[0]
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / NUM_CLASSES;
    localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_CLASSES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] drop_threshold_reg;
    logic [20:0] window_length_reg;
    logic [15:0] exempt_severity_reg;
    logic [15:0] summary_event_code_reg;
    logic [31:0] summary_source_reg;
    logic [15:0] summary_severity_reg;
    logic [7:0]  max_payload_length_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_threshold_reg     <= RST_DROP_THRESHOLD;
            window_length_reg      <= RST_WINDOW_LENGTH;
            exempt_severity_reg    <= RST_EXEMPT_SEVERITY;
            summary_event_code_reg <= RST_SUMMARY_EVENT_CODE;
            summary_source_reg     <= RST_SUMMARY_SOURCE;
            summary_severity_reg   <= RST_SUMMARY_SEVERITY;
            max_payload_length_reg <= RST_MAX_PAYLOAD_LENGTH;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DROP_THRESHOLD:     drop_threshold_reg     <= pwdata[15:0];
                REG_WINDOW_LENGTH:      window_length_reg      <= pwdata[20:0];
                REG_EXEMPT_SEVERITY:    exempt_severity_reg    <= pwdata[15:0];
                REG_SUMMARY_EVENT_CODE: summary_event_code_reg <= pwdata[15:0];
                REG_SUMMARY_SOURCE:     summary_source_reg     <= pwdata;
                REG_SUMMARY_SEVERITY:   summary_severity_reg   <= pwdata[15:0];
                REG_MAX_PAYLOAD_LENGTH: max_payload_length_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_DROP_THRESHOLD:     prdata = {16'd0, drop_threshold_reg};
            REG_WINDOW_LENGTH:      prdata = {11'd0, window_length_reg};
            REG_EXEMPT_SEVERITY:    prdata = {16'd0, exempt_severity_reg};
            REG_SUMMARY_EVENT_CODE: prdata = {16'd0, summary_event_code_reg};
            REG_SUMMARY_SOURCE:     prdata = summary_source_reg;
            REG_SUMMARY_SEVERITY:   prdata = {16'd0, summary_severity_reg};
            REG_MAX_PAYLOAD_LENGTH: prdata = {24'd0, max_payload_length_reg};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [63:0]            record_count_reg, record_count_next;
    logic [63:0]            window_start_reg, window_start_next;
    logic [NUM_CLASSES-1:0] entry_valid_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   out_load;

    // Held for the event in flight
    event_t                 ev_reg, ev_next;
    logic [11:0]            quot_reg, quot_next;
    logic                   exempt_reg, exempt_next;
    logic                   expired_reg, expired_next;
    logic                   drop_on_expiry_reg, drop_on_expiry_next;
    logic [CLS_W-1:0]       idx_reg, idx_next;

    // Class memory port
    logic                   ram_we, ram_re;
    logic [CLS_W-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

    ecrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CLASSES)
    ) u_class_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Class selection: (code >> 4) mod NUM_CLASSES by reciprocal
    // multiply; the estimate is registered, then fixed up by one subtract.
    // ------------------------------------------------------------------
    event_t           s_ev;
    logic [35:0]      quot_prod;
    logic [20:0]      quot_times_n;
    logic [20:0]      rem_wide;
    logic [9:0]       rem;
    logic [CLS_W-1:0] cls;

    assign s_ev      = event_t'(s_tdata);
    assign quot_prod = {24'd0, s_ev.ev_code[15:4]} * 36'(RECIP);

    assign quot_times_n = 21'(quot_reg) * 21'(NUM_CLASSES);
    assign rem_wide     = {9'd0, ev_reg.ev_code[15:4]} - quot_times_n;
    assign rem          = rem_wide[9:0];
    assign cls = (rem >= 10'(NUM_CLASSES)) ? CLS_W'(rem - 10'(NUM_CLASSES))
                                           : CLS_W'(rem);

    // ------------------------------------------------------------------
    // Decode of the incoming event and window state
    // ------------------------------------------------------------------
    logic        s_exempt;
    logic [63:0] window_span;
    logic        window_expired;

    assign s_exempt = (s_ev.severity >= exempt_severity_reg) ||
                      (s_ev.ev_code == summary_event_code_reg);
    assign window_span    = record_count_reg - window_start_reg;
    assign window_expired = (record_count_reg >= window_start_reg) &&
                            (window_span >= {43'd0, window_length_reg});

    // ------------------------------------------------------------------
    // Memory word decode (an unwritten class reads as zero)
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] sweep_word, event_word;
    logic [DROP_W-1:0]  sweep_dropped, ev_dropped, ev_dropped_inc;
    logic [CNT_W-1:0]   ev_count, ev_count_inc;
    logic               sweep_emit, ev_drop, out_free;
    append_t            sum_app, ev_app;

    assign sweep_word    = entry_valid_reg[idx_reg] ? ram_rdata : '0;
    assign sweep_dropped = sweep_word[ENTRY_W-1:CNT_W];
    assign sweep_emit    = (sweep_dropped != '0) && !drop_on_expiry_reg;

    // After an expiry sweep the class entry is known to be clear
    assign event_word = (expired_reg || !entry_valid_reg[cls]) ? '0 : ram_rdata;
    assign ev_count   = event_word[CNT_W-1:0];
    assign ev_dropped = event_word[ENTRY_W-1:CNT_W];
    assign ev_drop    = !exempt_reg && (ev_count >= drop_threshold_reg);

    assign ev_count_inc   = (&ev_count)   ? ev_count   : ev_count + 16'd1;
    assign ev_dropped_inc = (&ev_dropped) ? ev_dropped : ev_dropped + 32'd1;

    assign sum_app = do_append(record_count_reg, SUMMARY_PAYLOAD_LEN,
                               max_payload_length_reg);
    assign ev_app  = do_append(record_count_reg, ev_reg.pay_len,
                               max_payload_length_reg);

    assign out_free = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next          = state_reg;
        record_count_next   = record_count_reg;
        window_start_next   = window_start_reg;
        ev_next             = ev_reg;
        quot_next           = quot_reg;
        exempt_next         = exempt_reg;
        expired_next        = expired_reg;
        drop_on_expiry_next = drop_on_expiry_reg;
        idx_next            = idx_reg;
        ram_we              = 1'b0;
        ram_waddr           = cls;
        ram_wdata           = '0;
        ram_re              = 1'b0;
        ram_raddr           = cls;
        out_load            = 1'b0;
        out_next            = out_reg;
        s_tready            = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ev_next             = s_ev;
                    quot_next           = quot_prod[35:24];
                    exempt_next         = s_exempt;
                    expired_next        = window_expired;
                    drop_on_expiry_next = !s_exempt && (drop_threshold_reg == '0);
                    if (window_expired) begin
                        window_start_next = record_count_reg;
                        ram_re            = 1'b1;
                        ram_raddr         = '0;
                        idx_next          = '0;
                        state_next        = S_SWEEP;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK: begin
                ram_re     = 1'b1;
                ram_raddr  = cls;
                state_next = S_DECIDE;
            end

            // Snapshot and clear one class per cycle unless a summary waits,
            // emitting a summary for each class with drops unless the event drops
            S_SWEEP: begin
                if (!sweep_emit || out_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = '0;
                    if (sweep_emit) begin
                        out_load                 = 1'b1;
                        out_next.is_summary      = 1'b1;
                        out_next.record_seq      = sum_app.seq;
                        out_next.cpu_id          = ev_reg.cpu_id;
                        out_next.source          = summary_source_reg;
                        out_next.severity        = summary_severity_reg;
                        out_next.ev_code         = summary_event_code_reg;
                        out_next.summary_class   = 4'(idx_reg);
                        out_next.summary_dropped = sweep_dropped;
                        out_next.status          = sum_app.status;
                        out_next.last            = 1'b0;
                        record_count_next        = sum_app.count;
                    end
                    if (idx_reg == LAST_CLASS) begin
                        state_next = S_DECIDE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + CLS_W'(1);
                        idx_next  = idx_reg + CLS_W'(1);
                    end
                end
            end

            // Limit decision, append and the event's own result
            S_DECIDE: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    out_next.is_summary      = 1'b0;
                    out_next.cpu_id          = ev_reg.cpu_id;
                    out_next.source          = ev_reg.src_comp;
                    out_next.severity        = ev_reg.severity;
                    out_next.ev_code         = ev_reg.ev_code;
                    out_next.summary_class   = '0;
                    out_next.summary_dropped = '0;
                    out_next.last            = 1'b1;
                    ram_waddr                = cls;
                    if (ev_drop) begin
                        out_next.record_seq = '0;
                        out_next.status     = ST_DROPPED;
                        ram_we              = 1'b1;
                        ram_wdata           = {ev_dropped_inc, ev_count};
                    end else begin
                        out_next.record_seq = ev_app.seq;
                        out_next.status     = ev_app.status;
                        record_count_next   = ev_app.count;
                        // A failed append leaves the class count as it was
                        ram_we    = !exempt_reg;
                        ram_wdata = {ev_dropped,
                                     (ev_app.status == ST_LOGGED) ? ev_count_inc
                                                                  : ev_count};
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            record_count_reg <= '0;
            window_start_reg <= '0;
            entry_valid_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            record_count_reg <= record_count_next;
            window_start_reg <= window_start_next;
            out_valid_reg    <= out_valid_next;
            if (ram_we) begin
                entry_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ev_reg             <= ev_next;
        quot_reg           <= quot_next;
        exempt_reg         <= exempt_next;
        expired_reg        <= expired_next;
        drop_on_expiry_reg <= drop_on_expiry_next;
        idx_reg            <= idx_next;
        out_reg            <= out_next;
    end

    // ------------------------------------------------------------------
    // Output channel
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.is_summary;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_reg.status, out_reg.summary_dropped,
                       out_reg.summary_class, out_reg.ev_code,
                       out_reg.severity, out_reg.source, out_reg.cpu_id,
                       out_reg.record_seq};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Between events only the previous event's own result may be pending
    a_idle_no_summary_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && out_valid_reg) |-> out_reg.last)
        else $error("summary result pending while ready for a new event");

    // Summaries never close an event's result run
    a_summary_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.is_summary) |-> !out_reg.last)
        else $error("summary record marked last");

    // A dropped event writes no record
    a_drop_no_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == ST_DROPPED) |->
            (out_reg.record_seq == '0 && !out_reg.is_summary))
        else $error("dropped result carries a sequence number");

    // The sequence counter never moves backward
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (record_count_reg >= $past(record_count_reg)))
        else $error("record count decreased");

endmodule

`default_nettype wire

// ===== tb/ecrl_record_checker.sv =====
module ecrl_record_checker
    import ecrl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic                  pready,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // cpu_id, src_comp, severity, ev_code, pay_len
    input  wire logic [103:0]          s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // record_seq, out_cpu_id, out_source, out_severity, out_code,
    // summary_class, summary_dropped, status, zero fill
    input  wire logic [199:0]          m_tdata,
    // is_summary
    input  wire logic                  m_tuser,
    input  wire logic                  m_tlast,
    output int                         mismatch_count,
    output int                         results_pending,
    output int                         events_seen,
    output int                         summaries_seen,
    output int                         drops_seen,
    output int                         invalid_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES = 16;

    // Shadow copy of the configuration registers
    logic [15:0] cfg_threshold;
    logic [20:0] cfg_window;
    logic [15:0] cfg_exempt_sev;
    logic [15:0] cfg_summary_code;
    logic [31:0] cfg_summary_src;
    logic [15:0] cfg_summary_sev;
    logic [7:0]  cfg_max_payload;

    // Shadow copy of the limiter state
    logic [63:0] seq_count;
    logic [63:0] window_base;
    logic [15:0] class_accepted [CLASSES];
    logic [31:0] class_drops [CLASSES];

    result_t expected_records [$];
    result_t got;
    result_t want;

    // Claim the next sequence number unless the payload is too long or the
    // sequence space is used up
    function automatic status_t append_slot(input logic [7:0] len, output logic [63:0] seq);
        seq = '0;
        if (len > cfg_max_payload)
            return ST_INVALID;
        if (&seq_count)
            return ST_EXHAUSTED;
        seq_count = seq_count + 64'd1;
        seq = seq_count;
        return ST_LOGGED;
    endfunction

    function automatic result_t make_record(input logic summ, input logic [63:0] seq,
                                            input logic [31:0] cpu, input logic [31:0] src,
                                            input logic [15:0] sev, input logic [15:0] code,
                                            input logic [3:0] cls, input logic [31:0] drops,
                                            input status_t st, input logic fin);
        result_t r;
        r.is_summary      = summ;
        r.record_seq      = seq;
        r.cpu_id          = cpu;
        r.source          = src;
        r.severity        = sev;
        r.ev_code         = code;
        r.summary_class   = cls;
        r.summary_dropped = drops;
        r.status          = st;
        r.last            = fin;
        return r;
    endfunction

    function automatic string show(input result_t r);
        string head;
        head = $sformatf("summ=%0d seq=%0h cpu=%0h src=%0h sev=%0h code=%0h",
                         r.is_summary, r.record_seq, r.cpu_id, r.source, r.severity,
                         r.ev_code);
        return {head, $sformatf(" cls=%0d drop=%0d st=%0d last=%0d",
                                r.summary_class, r.summary_dropped, r.status, r.last)};
    endfunction

    // Work out the records one event causes and queue them in order
    task automatic predict_records(input event_t ev);
        logic [31:0] snap [CLASSES];
        logic        any_drops;
        logic        exempt;
        logic [3:0]  cls;
        logic [15:0] prior;
        logic [63:0] seq;
        status_t     st;
        int          i;

        any_drops = 1'b0;
        cls = '0;
        prior = '0;
        for (i = 0; i < CLASSES; i++)
            snap[i] = '0;

        // window rollover: snapshot drops, clear all class counters
        if (seq_count >= window_base && (seq_count - window_base) >= cfg_window) begin
            for (i = 0; i < CLASSES; i++) begin
                snap[i] = class_drops[i];
                if (class_drops[i] != 0)
                    any_drops = 1'b1;
                class_accepted[i] = '0;
                class_drops[i] = '0;
            end
            window_base = seq_count;
        end

        exempt = (ev.severity >= cfg_exempt_sev) || (ev.ev_code == cfg_summary_code);
        if (!exempt) begin
            cls = ev.ev_code[7:4];
            if (class_accepted[cls] >= cfg_threshold) begin
                // dropped: the snapshot is thrown away
                if (!(&class_drops[cls]))
                    class_drops[cls] = class_drops[cls] + 32'd1;
                expected_records.push_back(make_record(1'b0, '0, ev.cpu_id,
                    ev.src_comp, ev.severity, ev.ev_code, '0, '0,
                    ST_DROPPED, 1'b1));
                return;
            end
            prior = class_accepted[cls];
            if (!(&class_accepted[cls]))
                class_accepted[cls] = class_accepted[cls] + 16'd1;
        end

        // one summary per class that dropped in the closed window
        if (any_drops) begin
            for (i = 0; i < CLASSES; i++) begin
                if (snap[i] != 0) begin
                    st = append_slot(SUMMARY_PAYLOAD_LEN, seq);
                    expected_records.push_back(make_record(1'b1, seq, ev.cpu_id,
                        cfg_summary_src, cfg_summary_sev, cfg_summary_code, 4'(i),
                        snap[i], st, 1'b0));
                end
            end
        end

        st = append_slot(ev.pay_len, seq);
        if (st != ST_LOGGED && !exempt)
            class_accepted[cls] = prior;
        expected_records.push_back(make_record(1'b0, seq, ev.cpu_id, ev.src_comp,
            ev.severity, ev.ev_code, '0, '0, st, 1'b1));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_threshold    = RST_DROP_THRESHOLD;
            cfg_window       = RST_WINDOW_LENGTH;
            cfg_exempt_sev   = RST_EXEMPT_SEVERITY;
            cfg_summary_code = RST_SUMMARY_EVENT_CODE;
            cfg_summary_src  = RST_SUMMARY_SOURCE;
            cfg_summary_sev  = RST_SUMMARY_SEVERITY;
            cfg_max_payload  = RST_MAX_PAYLOAD_LENGTH;
            seq_count   = '0;
            window_base = '0;
            for (int i = 0; i < CLASSES; i++) begin
                class_accepted[i] = '0;
                class_drops[i] = '0;
            end
            expected_records.delete();
            mismatch_count = 0;
            events_seen    = 0;
            summaries_seen = 0;
            drops_seen     = 0;
            invalid_seen   = 0;
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_DROP_THRESHOLD:     cfg_threshold    = pwdata[15:0];
                    REG_WINDOW_LENGTH:      cfg_window       = pwdata[20:0];
                    REG_EXEMPT_SEVERITY:    cfg_exempt_sev   = pwdata[15:0];
                    REG_SUMMARY_EVENT_CODE: cfg_summary_code = pwdata[15:0];
                    REG_SUMMARY_SOURCE:     cfg_summary_src  = pwdata[31:0];
                    REG_SUMMARY_SEVERITY:   cfg_summary_sev  = pwdata[15:0];
                    REG_MAX_PAYLOAD_LENGTH: cfg_max_payload  = pwdata[7:0];
                    default: ;
                endcase
            end

            // event transaction
            if (s_tvalid && s_tready) begin
                predict_records(event_t'(s_tdata));
                events_seen++;
            end

            // result transaction
            if (m_tvalid && m_tready) begin
                got.is_summary      = m_tuser;
                got.record_seq      = m_tdata[63:0];
                got.cpu_id          = m_tdata[95:64];
                got.source          = m_tdata[127:96];
                got.severity        = m_tdata[143:128];
                got.ev_code         = m_tdata[159:144];
                got.summary_class   = m_tdata[163:160];
                got.summary_dropped = m_tdata[195:164];
                got.status          = status_t'(m_tdata[197:196]);
                got.last            = m_tlast;
                if (got.is_summary === 1'b1)
                    summaries_seen++;
                if (got.status === ST_DROPPED)
                    drops_seen++;
                if (got.status === ST_INVALID)
                    invalid_seen++;
                if (expected_records.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected record %s", $time, show(got));
                end else begin
                    want = expected_records.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: record mismatch\n  expected %s\n  actual   %s",
                                     $time, show(want), show(got));
                    end
                end
            end
        end
        results_pending <= expected_records.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench
    import ecrl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [103:0]          s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [199:0]          m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatch_count;
    int results_pending;
    int events_seen;
    int summaries_seen;
    int drops_seen;
    int invalid_seen;

    // no idling on either side while set
    logic steady_run = 1'b0;
    int   phase_count = 0;

    // stimulus-side copy of the fields that shape random events
    logic [15:0] cfg_exempt = RST_EXEMPT_SEVERITY;
    logic [15:0] cfg_code   = RST_SUMMARY_EVENT_CODE;
    logic [7:0]  cfg_maxlen = RST_MAX_PAYLOAD_LENGTH;

    event_class_rate_limiter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ecrl_record_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .events_seen     (events_seen),
        .summaries_seen  (summaries_seen),
        .drops_seen      (drops_seen),
        .invalid_seen    (invalid_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= steady_run ? 1'b1 : ($urandom_range(0, 99) >= 8);
    end

    initial begin
        #5_000_000;
        $display("event_class_rate_limiter_top test failed");
        $finish;
    end

    function automatic event_t make_event(input logic [31:0] cpu, input logic [31:0] src,
                                          input logic [15:0] sev, input logic [15:0] code,
                                          input logic [7:0] plen);
        event_t ev;
        ev.cpu_id = cpu;
        ev.src_comp = src;
        ev.severity = sev;
        ev.ev_code = code;
        ev.pay_len = plen;
        return ev;
    endfunction

    // Mostly limited events in a few busy classes with legal payloads
    function automatic event_t random_event();
        event_t     ev;
        logic [3:0] cls;
        ev.cpu_id = $urandom;
        ev.src_comp = $urandom;
        if ($urandom_range(0, 99) < 85 && cfg_exempt != 0)
            ev.severity = 16'($urandom_range(0, cfg_exempt - 1));
        else
            ev.severity = 16'($urandom);
        cls = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        ev.ev_code = {8'($urandom), cls, 4'($urandom)};
        if ($urandom_range(0, 99) < 8)
            ev.ev_code = cfg_code;
        if ($urandom_range(0, 99) < 88)
            ev.pay_len = 8'($urandom_range(0, cfg_maxlen));
        else
            ev.pay_len = 8'($urandom);
        return ev;
    endfunction

    // Present one event and hold it until the transaction completes; valid
    // stays high into the next event unless a gap is taken
    task automatic send_event(input event_t ev);
        s_tdata  <= ev;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!steady_run && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop sending and let every expected record come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [20:0] win,
                              input logic [15:0] exs, input logic [15:0] code,
                              input logic [31:0] src, input logic [15:0] sev,
                              input logic [7:0] maxlen);
        wait_drain();
        apb_write(REG_DROP_THRESHOLD, {16'd0, thr});
        apb_write(REG_WINDOW_LENGTH, {11'd0, win});
        apb_write(REG_EXEMPT_SEVERITY, {16'd0, exs});
        apb_write(REG_SUMMARY_EVENT_CODE, {16'd0, code});
        apb_write(REG_SUMMARY_SOURCE, src);
        apb_write(REG_SUMMARY_SEVERITY, {16'd0, sev});
        apb_write(REG_MAX_PAYLOAD_LENGTH, {24'd0, maxlen});
        cfg_exempt = exs;
        cfg_code   = code;
        cfg_maxlen = maxlen;
        phase_count++;
    endtask

    task automatic random_config();
        logic [15:0] thr;
        logic [20:0] win;
        logic [15:0] exs;
        logic [7:0]  mpl;
        case ($urandom_range(0, 7))
            0: thr = 16'd0;
            1: thr = 16'hFFFF;
            2: thr = 16'($urandom);
            default: thr = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            0: win = 21'd0;
            1: win = 21'd1048576;
            2: win = 21'h1FFFFF;
            default: win = 21'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0: exs = 16'd0;
            1: exs = 16'hFFFF;
            default: exs = 16'($urandom_range(2, 16'h7FFF));
        endcase
        case ($urandom_range(0, 5))
            0: mpl = 8'($urandom_range(0, 7));
            1: mpl = 8'hFF;
            default: mpl = 8'($urandom_range(200, 254));
        endcase
        set_config(thr, win, exs, 16'($urandom), $urandom, 16'($urandom), mpl);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: field extremes, exempt by severity and by code,
        // length at and over the limit, rollback of a counted event
        send_event(make_event('0, '0, 16'd0, 16'h0010, 8'd0));
        send_event(make_event('1, '1, 16'hFFFF, 16'hFFFF, 8'd255));
        send_event(make_event(32'h1234_5678, 32'h0BAD_F00D, 16'd2, 16'h0000, 8'd220));
        send_event(make_event(32'h8000_0001, 32'h7FFF_FFFE, 16'd1, 16'h0123, 8'd221));
        phase_count++;

        // tight limit: class 3 fills up and drops, then the window closes
        // and a summary precedes the next event
        set_config(16'd2, 21'd6, 16'h0100, 16'hABCD, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
        repeat (5) send_event(make_event($urandom, $urandom, 16'd1, 16'h0035, 8'd10));
        send_event(make_event($urandom, $urandom, 16'd0, 16'hABCD, 8'd255));
        send_event(make_event($urandom, $urandom, 16'h0100, 16'h0037, 8'd0));
        send_event(make_event($urandom, $urandom, 16'd1, 16'h0031, 8'd10));
        send_event(make_event($urandom, $urandom, 16'd1, 16'h0032, 8'd10));

        // threshold lowered below the current class count: still dropped
        set_config(16'd1, 21'd6, 16'h0100, 16'hABCD, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
        send_event(make_event($urandom, $urandom, 16'd1, 16'h0033, 8'd10));

        // zero window and zero threshold, summaries too long for the limit
        set_config(16'd0, 21'd0, 16'h8000, 16'h5555, 32'h0000_0001, 16'h0000, 8'd0);
        send_event(make_event($urandom, $urandom, 16'd5, 16'h0000, 8'd0));
        send_event(make_event($urandom, $urandom, 16'h8000, 16'h0000, 8'd0));
        send_event(make_event($urandom, $urandom, 16'd5, 16'h00F0, 8'd0));
        send_event(make_event($urandom, $urandom, 16'd5, 16'h0010, 8'd0));
        send_event(make_event($urandom, $urandom, 16'hFFFF, 16'h00A0, 8'd1));

        // zero window with a nonzero threshold: counters cleared every event
        set_config(16'd1, 21'd0, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 16'h0001, 8'd255);
        repeat (3) send_event(make_event($urandom, $urandom, 16'd0, 16'h0020, 8'd255));

        // random phases
        for (int p = 0; p < 6; p++) begin
            random_config();
            steady_run <= (p == 2);
            for (int n = 0; n < 35; n++) begin
                if (p == 3 && n == 17)
                    wait_drain();
                send_event(random_event());
            end
        end

        wait_drain();
        steady_run <= 1'b0;
        repeat (40) @(posedge aclk);

        $display("Run covered %0d events over %0d configuration phases:", events_seen,
                 phase_count);
        $display("%0d summary records, %0d drops, %0d invalid-length results.",
                 summaries_seen, drops_seen, invalid_seen);
        if (mismatch_count == 0 && results_pending == 0)
            $display("event_class_rate_limiter_top test passed");
        else
            $display("event_class_rate_limiter_top test failed");
        $finish;
    end

endmodule
